>>> rtl/tasp_pkg.sv
// Package for the two-axis pose sequencer: codes, zone names, progress steps
// and the structs that pass between the input register, the decision logic and the top.
// No dependencies.
package tasp_pkg;

  // request codes
  localparam logic [1:0] FUNC_STOP    = 2'd0;
  localparam logic [1:0] FUNC_SLEEP   = 2'd1;
  localparam logic [1:0] FUNC_LOUNGE  = 2'd2;
  localparam logic [1:0] FUNC_INVALID = 2'd3;

  // pose codes
  localparam logic [1:0] POSE_UNKNOWN = 2'd0;

  // lift zones
  localparam logic [2:0] LZ_LOWER_LIMIT = 3'd0;
  localparam logic [2:0] LZ_BELOW_SAFE  = 3'd1;
  localparam logic [2:0] LZ_IN_SAFE     = 3'd2;
  localparam logic [2:0] LZ_ABOVE_SAFE  = 3'd3;
  localparam logic [2:0] LZ_ABOVE_CEIL  = 3'd4;
  localparam logic [2:0] LZ_UPPER_LIMIT = 3'd5;

  // span zones
  localparam logic [1:0] SZ_RETRACTED = 2'd0;
  localparam logic [1:0] SZ_EXTENDED  = 2'd1;

  // actuator answers
  localparam logic [1:0] ANS_BUSY = 2'd1;

  // progress steps in percent
  localparam logic [6:0] PROG_0   = 7'd0;
  localparam logic [6:0] PROG_20  = 7'd20;
  localparam logic [6:0] PROG_40  = 7'd40;
  localparam logic [6:0] PROG_60  = 7'd60;
  localparam logic [6:0] PROG_80  = 7'd80;
  localparam logic [6:0] PROG_100 = 7'd100;

  typedef enum logic [1:0] {
    LC_STANDBY = 2'd0,
    LC_RAISE   = 2'd1,
    LC_LOWER   = 2'd2,
    LC_NONE    = 2'd3
  } lift_cmd_e;

  typedef enum logic [2:0] {
    SC_WAKE    = 3'd0,
    SC_SLEEP   = 3'd1,
    SC_EXTEND  = 3'd2,
    SC_RETRACT = 3'd3,
    SC_NONE    = 3'd4
  } span_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_MOVING  = 3'd1,
    ST_ABORTED = 3'd2,
    ST_DONE    = 3'd3,
    ST_ERROR   = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    RC_DONE = 3'd0,
    RC_BUSY = 3'd1,
    RC_LIFT = 3'd2,
    RC_SPAN = 3'd3,
    RC_BAD  = 3'd4
  } result_e;

  typedef struct packed {
    logic [1:0] func;
    logic [2:0] lift_zone;
    logic [1:0] span_zone;
    logic [1:0] lift_answer;
    logic [1:0] span_answer;
  } item_t;

  typedef struct packed {
    mode_e      mode;
    logic [1:0] cur_pose;
    logic [1:0] tgt_pose;
    logic [6:0] progress;
    logic       wait_span;
  } seq_state_t;

  typedef struct packed {
    lift_cmd_e  lift_cmd;
    span_cmd_e  span_cmd;
    logic [6:0] progress;
    mode_e      mode;
    logic [1:0] cur_pose;
    logic [1:0] tgt_pose;
    result_e    rc;
  } result_t;

endpackage

>>> rtl/tasp_in_reg.sv
// Input register of the pose sequencer: holds one accepted poll until the
// decision stage takes it. Depends on tasp_pkg.
module tasp_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tasp_pkg::item_t item_i,
  input  logic          advance_i,
  output logic          valid_o,
  output tasp_pkg::item_t item_o
);
  import tasp_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  // free when empty or when the held poll moves on this cycle
  assign in_ready_o = !valid_q || advance_i;

  // occupancy
  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload capture
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> rtl/tasp_decide.sv
// Interlock decision table of the pose sequencer: from one poll and the
// present state, the next state and the result. Depends on tasp_pkg.
module tasp_decide (
  input  tasp_pkg::item_t      item_i,
  input  tasp_pkg::seq_state_t st_i,
  input  logic                 together_i,
  output tasp_pkg::seq_state_t st_o,
  output tasp_pkg::result_t    res_o
);
  import tasp_pkg::*;

  logic       lfault, sfault, lbusy, sbusy, ext, ret, bad, final_row;
  lift_cmd_e  lc;
  span_cmd_e  sc;
  result_e    rc;
  seq_state_t nxt;

  assign lfault = item_i.lift_answer[1];
  assign sfault = item_i.span_answer[1];
  assign lbusy  = item_i.lift_answer == ANS_BUSY;
  assign sbusy  = item_i.span_answer == ANS_BUSY;
  assign ext    = item_i.span_zone == SZ_EXTENDED;
  assign ret    = item_i.span_zone == SZ_RETRACTED;

  always_comb begin
    nxt       = st_i;
    lc        = LC_NONE;
    sc        = SC_NONE;
    rc        = RC_DONE;
    bad       = 1'b0;
    final_row = 1'b0;

    if (item_i.func == FUNC_STOP) begin
      // stop: drop target, abort a move, park both axes
      nxt.tgt_pose = POSE_UNKNOWN;
      if (st_i.mode == ST_MOVING) begin
        nxt.mode = ST_ABORTED;
      end
      lc = LC_STANDBY;
      sc = SC_SLEEP;
      if (lbusy || sbusy) begin
        rc = RC_BUSY;
      end else if (lfault) begin
        nxt.mode = ST_ERROR;
        rc       = RC_LIFT;
      end else if (sfault) begin
        nxt.mode = ST_ERROR;
        rc       = RC_SPAN;
      end
    end else begin
      // start of a new move
      if (st_i.mode != ST_MOVING || item_i.func != st_i.tgt_pose) begin
        nxt.mode      = ST_MOVING;
        nxt.cur_pose  = POSE_UNKNOWN;
        nxt.tgt_pose  = item_i.func;
        nxt.progress  = PROG_0;
        nxt.wait_span = 1'b0;
      end

      case (item_i.func)
        FUNC_SLEEP: begin
          // toward sleep: lift down, span extended on the way through the safe zone
          case (item_i.lift_zone)
            LZ_LOWER_LIMIT: begin
              if (ext) begin
                lc = LC_STANDBY; sc = SC_SLEEP; nxt.progress = PROG_100; final_row = 1'b1;
              end else begin
                lc = LC_RAISE; sc = SC_WAKE; nxt.progress = PROG_0; nxt.wait_span = 1'b1;
              end
            end
            LZ_BELOW_SAFE: begin
              if (ext) begin
                lc = LC_LOWER; sc = SC_WAKE; nxt.progress = PROG_80;
              end else begin
                lc = LC_RAISE; sc = SC_WAKE; nxt.progress = PROG_20; nxt.wait_span = 1'b1;
              end
            end
            LZ_IN_SAFE: begin
              if (ext) begin
                lc = LC_LOWER; sc = SC_WAKE; nxt.progress = PROG_60;
              end else begin
                sc = SC_EXTEND;
                lc = (together_i && !nxt.wait_span) ? LC_LOWER : LC_STANDBY;
                nxt.progress = PROG_40;
              end
            end
            LZ_ABOVE_SAFE: begin
              lc = LC_LOWER; sc = SC_WAKE; nxt.progress = PROG_20;
            end
            LZ_ABOVE_CEIL, LZ_UPPER_LIMIT: begin
              lc = LC_LOWER; sc = SC_WAKE; nxt.progress = PROG_0;
            end
            default: begin
              bad = 1'b1;
            end
          endcase
        end
        FUNC_LOUNGE: begin
          // toward lounge: lift up, span retracted from the safe zone upward
          case (item_i.lift_zone)
            LZ_LOWER_LIMIT: begin
              lc = LC_RAISE; sc = SC_WAKE; nxt.progress = PROG_0;
            end
            LZ_BELOW_SAFE: begin
              lc = LC_RAISE; sc = SC_WAKE; nxt.progress = PROG_20;
            end
            LZ_IN_SAFE: begin
              if (ret) begin
                lc = LC_RAISE; sc = SC_WAKE; nxt.progress = PROG_60;
              end else begin
                sc = SC_RETRACT;
                lc = together_i ? LC_RAISE : LC_STANDBY;
                nxt.progress = PROG_40;
              end
            end
            LZ_ABOVE_SAFE: begin
              if (ret) begin
                lc = LC_RAISE; sc = SC_WAKE; nxt.progress = PROG_80;
              end else begin
                lc = LC_STANDBY; sc = SC_RETRACT; nxt.progress = PROG_60;
              end
            end
            LZ_ABOVE_CEIL, LZ_UPPER_LIMIT: begin
              if (ret) begin
                lc = LC_STANDBY; sc = SC_SLEEP; nxt.progress = PROG_100; final_row = 1'b1;
              end else begin
                lc = LC_STANDBY; sc = SC_RETRACT; nxt.progress = PROG_80;
              end
            end
            default: begin
              bad = 1'b1;
            end
          endcase
        end
        default: begin
          bad = 1'b1;
        end
      endcase

      // outcome of the move step
      if (bad) begin
        nxt.mode = ST_ERROR;
        rc       = RC_BAD;
        lc       = LC_NONE;
        sc       = SC_NONE;
      end else if (lfault) begin
        nxt.mode = ST_ERROR;
        rc       = RC_LIFT;
      end else if (sfault) begin
        nxt.mode = ST_ERROR;
        rc       = RC_SPAN;
      end else if (lbusy || sbusy || !final_row) begin
        rc = RC_BUSY;
      end else begin
        nxt.cur_pose = item_i.func;
        nxt.mode     = ST_DONE;
        nxt.progress = PROG_100;
        rc           = RC_DONE;
      end
    end
  end

  assign st_o = nxt;

  // result reports the state after this poll
  assign res_o = '{lift_cmd: lc, span_cmd: sc, progress: nxt.progress, mode: nxt.mode,
                   cur_pose: nxt.cur_pose, tgt_pose: nxt.tgt_pose, rc: rc};

endmodule

>>> rtl/two_axis_pose_sequencer_top.sv
// A poll goes from the input register through the decision table into the result
// register; it waits in the input register while a result is held and not taken.
// Throughput: one poll per cycle while results are taken; the input register holds
// one poll while a result waits. Reset clears the state to idle, poses to unknown,
// progress and wait flag to zero, both stages empty, move-together register to 1.
// Top level of the pose sequencer; depends on tasp_pkg, tasp_in_reg, tasp_decide.
module two_axis_pose_sequencer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] func_i,
  input  logic [2:0] lift_zone_i,
  input  logic [1:0] span_zone_i,
  input  logic [1:0] lift_answer_i,
  input  logic [1:0] span_answer_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] lift_command_o,
  output logic [2:0] span_command_o,
  output logic [6:0] progress_percent_o,
  output logic [2:0] machine_state_o,
  output logic [1:0] pose_reached_o,
  output logic [1:0] pose_wanted_o,
  output logic [2:0] result_code_o
);
  import tasp_pkg::*;

  logic       together_q;
  logic       stage_valid, advance;
  item_t      item_in, stage_item;
  seq_state_t st_q, st_d;
  result_t    res_d, res_q;
  logic       out_valid_q, out_valid_d;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      together_q <= 1'b1;
    end else if (cfg_we_i) begin
      together_q <= cfg_wdata_i;
    end
  end

  assign item_in = '{func: func_i, lift_zone: lift_zone_i, span_zone: span_zone_i,
                     lift_answer: lift_answer_i, span_answer: span_answer_i};

  // held poll moves on when the result register is free or being emptied
  assign advance = stage_valid && (!out_valid_q || out_ready_i);

  tasp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (item_in),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  tasp_decide u_decide (
    .item_i     (stage_item),
    .st_i       (st_q),
    .together_i (together_q),
    .st_o       (st_d),
    .res_o      (res_d)
  );

  // sequencer state, updated once per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode      <= ST_IDLE;
      st_q.cur_pose  <= POSE_UNKNOWN;
      st_q.tgt_pose  <= POSE_UNKNOWN;
      st_q.progress  <= PROG_0;
      st_q.wait_span <= 1'b0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // result register occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign lift_command_o     = res_q.lift_cmd;
  assign span_command_o     = res_q.span_cmd;
  assign progress_percent_o = res_q.progress;
  assign machine_state_o    = res_q.mode;
  assign pose_reached_o     = res_q.cur_pose;
  assign pose_wanted_o      = res_q.tgt_pose;
  assign result_code_o      = res_q.rc;

  // bad state never drives an axis and always lands in error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.rc == RC_BAD) |->
      (res_q.lift_cmd == LC_NONE && res_q.span_cmd == SC_NONE && res_q.mode == ST_ERROR))
    else $error("bad state result with a drive command or without error state");

  // actuator faults end in error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.rc == RC_LIFT || res_q.rc == RC_SPAN)) |-> res_q.mode == ST_ERROR)
    else $error("fault result without error state");

  // a known current pose only survives in done or error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.cur_pose != POSE_UNKNOWN) |-> (st_q.mode == ST_DONE || st_q.mode == ST_ERROR))
    else $error("current pose known outside done or error");

  // progress stays a percentage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.progress <= PROG_100)
    else $error("progress above 100 percent");

  // input side only stalls when both stages are full and the result is not taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (stage_valid && out_valid_q && !out_ready_i))
    else $error("input stalled with room in the pipeline");

endmodule
